/* sv/hia_pkg.sv */
// shared types, codes and defaults for the handle id allocator
package hia_pkg;

	localparam int unsigned STACK_DEPTH_DEF  = 256;
	localparam int unsigned HANDLE_WIDTH_DEF = 16;

	localparam int unsigned FIELD_W  = 16;
	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CFG_IDX_W = 1;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_RESET = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STS_INVALID   = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] STS_EXHAUSTED = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_INVALID = 1'b1;

	localparam logic [FIELD_W-1:0] START_RST   = 16'd1;
	localparam logic [FIELD_W-1:0] INVALID_RST = 16'd0;

	typedef struct packed {
		logic [FIELD_W-1:0] start_value;
		logic [FIELD_W-1:0] invalid_value;
	} cfg_t;

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

endpackage

/* sv/hia_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module hia_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/hia_engine.sv */
// allocate / free / reset sequencer around the free stack memory
module hia_engine
	import hia_pkg::*;
#(
	parameter int unsigned STACK_DEPTH  = STACK_DEPTH_DEF,
	parameter int unsigned HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfg_t                           cfg,
	input  logic                           start,
	input  logic [FUNC_W-1:0]              func,
	input  logic [FIELD_W-1:0]             handle,
	output logic                           busy,
	output logic                           done,
	output logic [FIELD_W-1:0]             handle_out,
	output logic [STATUS_W-1:0]            status,
	output logic                           ram_we,
	output logic [$clog2(STACK_DEPTH)-1:0] ram_waddr,
	output logic [HANDLE_WIDTH-1:0]        ram_wdata,
	output logic                           ram_re,
	output logic [$clog2(STACK_DEPTH)-1:0] ram_raddr,
	input  logic [HANDLE_WIDTH-1:0]        ram_rdata
);

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	state_t                state_q, state_d;
	logic [CW-1:0]         count_q, count_d, count_m1;
	logic [HANDLE_WIDTH:0] next_q, next_d, next_m1;
	logic                  done_q;
	logic [HANDLE_WIDTH-1:0] res_q, res_d;
	logic [STATUS_W-1:0]   stat_q, stat_d;
	logic                  acc;
	logic                  pop_go;
	logic [HANDLE_WIDTH-1:0] h;
	logic [HANDLE_WIDTH-1:0] inv_h;
	logic [HANDLE_WIDTH-1:0] start_h;

	assign h        = HANDLE_WIDTH'(handle);
	assign inv_h    = HANDLE_WIDTH'(cfg.invalid_value);
	assign start_h  = HANDLE_WIDTH'(cfg.start_value);
	assign count_m1 = count_q - 1'b1;
	assign next_m1  = next_q - 1'b1;
	assign acc      = start && (state_q == ST_IDLE);

	// per-operation datapath
	always_comb begin
		next_d    = next_q;
		count_d   = count_q;
		res_d     = '0;
		stat_d    = STS_OK;
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = h;
		ram_re    = 1'b0;
		ram_raddr = count_m1[AW-1:0];
		pop_go    = 1'b0;
		if (acc) begin
			unique case (func)
				FN_ALLOC: begin
					if (count_q != '0) begin
						ram_re  = 1'b1;
						count_d = count_m1;
						pop_go  = 1'b1;
					end else if (next_q[HANDLE_WIDTH]) begin
						stat_d = STS_EXHAUSTED;
					end else begin
						res_d  = next_q[HANDLE_WIDTH-1:0];
						next_d = next_q + 1'b1;
					end
				end
				FN_FREE: begin
					if (h == inv_h) begin
						stat_d = STS_INVALID;
					end else if ((next_q != '0) && ({1'b0, h} == next_m1)) begin
						next_d = next_m1;
					end else if (count_q == CW'(STACK_DEPTH)) begin
						stat_d = STS_FULL;
					end else begin
						ram_we  = 1'b1;
						count_d = count_q + 1'b1;
					end
				end
				FN_RESET: begin
					count_d = '0;
					next_d  = {1'b0, start_h};
				end
				default: begin
				end
			endcase
		end
	end

	// next state
	always_comb begin
		unique case (state_q)
			ST_IDLE: state_d = pop_go ? ST_POP : ST_IDLE;
			ST_POP:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: popped word comes straight from the ram read register
	always_comb begin
		busy       = (state_q == ST_POP);
		done       = done_q || busy;
		handle_out = busy ? FIELD_W'(ram_rdata) : FIELD_W'(res_q);
		status     = busy ? STS_OK : stat_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			next_q  <= {1'b0, HANDLE_WIDTH'(START_RST)};
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			next_q  <= next_d;
			done_q  <= acc && !pop_go;
		end
	end

	always_ff @(posedge clk) begin
		res_q  <= res_d;
		stat_q <= stat_d;
	end

endmodule

/* sv/handle_id_allocator_top.sv */
// handle id allocator: lifo free stack in ram plus a high-water counter
// every word's result strobes done in the cycle after it is accepted, never stalled
// a new command can follow free, reset and counter allocates with no hold-off; an allocate
//   that pops the stack holds off the next command while busy is high for the free-stack ram read
// reset: arst_n clears the stack count, loads the counter with the start value,
//   config to start 1 / invalid 0; ram contents are left as they are
module handle_id_allocator_top
	import hia_pkg::*;
#(
	parameter int unsigned STACK_DEPTH  = STACK_DEPTH_DEF,
	parameter int unsigned HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// command word
	input  logic                 start,
	output logic                 busy,
	input  logic [FUNC_W-1:0]    func,
	input  logic [FIELD_W-1:0]   handle,
	// result word
	output logic                 done,
	output logic [FIELD_W-1:0]   handle_out,
	output logic [STATUS_W-1:0]  status,
	// config write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FIELD_W-1:0]   cfg_data
);

	localparam int unsigned AW = $clog2(STACK_DEPTH);

	cfg_t                    cfg_q;
	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [HANDLE_WIDTH-1:0] ram_wdata;
	logic                    ram_re;
	logic [AW-1:0]           ram_raddr;
	logic [HANDLE_WIDTH-1:0] ram_rdata;

	// config registers always take a write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_value   <= START_RST;
			cfg_q.invalid_value <= INVALID_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_START:   cfg_q.start_value   <= cfg_data;
				CFG_INVALID: cfg_q.invalid_value <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer: decodes the command, owns counter and stack pointer
	hia_engine #(
		.STACK_DEPTH  (STACK_DEPTH),
		.HANDLE_WIDTH (HANDLE_WIDTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.start      (start),
		.func       (func),
		.handle     (handle),
		.busy       (busy),
		.done       (done),
		.handle_out (handle_out),
		.status     (status),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	// free stack storage, one push or one pop per cycle while the engine is not busy
	hia_ram #(
		.WIDTH (HANDLE_WIDTH),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

`ifndef NO_ASSERTIONS
	// every accepted word gives its result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("no result after accepted command");

	// no result without a command the cycle before
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result strobe without a command");

	// a pop holds off commands for exactly one cycle
	a_busy_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	// failed operations never hand out a handle
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != STS_OK)) |-> (handle_out == '0))
		else $error("handle returned with a failing status");
`endif

endmodule
